### sv/sbmq_pkg.sv
// Shared types and constants for the shared-buffer multi-queue block.
`default_nettype none

package sbmq_pkg;

   // Beat payload widths fixed by the interface
   localparam int DATA_W   = 32;
   localparam int QID_W    = 2;

   typedef logic [QID_W-1:0] qid_type;

   // Operation codes carried in the op field
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   localparam logic signed [DATA_W-1:0] MINUS_ONE = -32'sd1;

   // Strobes to the slot store
   typedef struct packed {
      logic rd_en;       // read link and data at rd_addr
      logic link_wr_en;  // write one link entry
      logic data_wr_en;  // write one data entry
      logic alloc;       // the written data slot has just left the free list
   } slot_ctl_type;

   // Strobes to the queue table
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } qtab_ctl_type;

endpackage

`default_nettype wire

### sv/sbmq_ifs.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface sbmq_req_if;
   logic                              valid;
   logic                              ready;
   logic                              op;
   logic [sbmq_pkg::QID_W-1:0]        queue_id;
   logic signed [sbmq_pkg::DATA_W-1:0] data_in;

   modport source (output valid, output op, output queue_id, output data_in, input ready);
   modport sink   (input valid, input op, input queue_id, input data_in, output ready);
endinterface

interface sbmq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sbmq_pkg::DATA_W-1:0] data_out;
   logic [1:0]                        status;

   modport source (output valid, output data_out, output status, input ready);
   modport sink   (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

### sv/sbmq_slots.sv
// Slot store: data and next-link memories with a fresh-slot watermark.
`default_nettype none

module sbmq_slots #(
   parameter int SLOTS = 16,
   parameter int SW    = 4,
   parameter int LW    = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sbmq_pkg::slot_ctl_type             ctl,
   input  wire logic [SW-1:0]                      rd_addr,
   input  wire logic [SW-1:0]                      link_wr_addr,
   input  wire logic [LW-1:0]                      link_wr_data,
   input  wire logic [SW-1:0]                      data_wr_addr,
   input  wire logic signed [sbmq_pkg::DATA_W-1:0] data_wr_data,
   output logic [LW-1:0]                           link_rd_data,
   output logic signed [sbmq_pkg::DATA_W-1:0]      data_rd_data
);

   logic [LW-1:0]                      link_mem [SLOTS];
   logic signed [sbmq_pkg::DATA_W-1:0] data_mem [SLOTS];

   logic [LW-1:0]                      link_q_ff;
   logic signed [sbmq_pkg::DATA_W-1:0] data_q_ff;
   logic                               fresh_ff;
   logic [LW-1:0]                      succ_ff;

   // Slots at or above the watermark have never been allocated, so their
   // link is still the reset chain: the next slot, or null after the last.
   logic [LW-1:0] mark_ff;
   logic [LW-1:0] mark_in;

   always_comb begin
      mark_in = mark_ff;
      if (ctl.alloc && (LW'(data_wr_addr) == mark_ff)) begin
         mark_in = mark_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (ctl.link_wr_en) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (ctl.data_wr_en) begin
         data_mem[data_wr_addr] <= data_wr_data;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         link_q_ff <= link_mem[rd_addr];
         data_q_ff <= data_mem[rd_addr];
         fresh_ff  <= (LW'(rd_addr) >= mark_ff);
         succ_ff   <= LW'(rd_addr) + LW'(1);
      end
   end

   assign link_rd_data = fresh_ff ? succ_ff : link_q_ff;
   assign data_rd_data = data_q_ff;

endmodule

`default_nettype wire

### sv/sbmq_qtab.sv
// Queue table: head and tail link per queue in one memory, with valid bits.
`default_nettype none

module sbmq_qtab #(
   parameter int SLOTS  = 16,
   parameter int QUEUES = 4,
   parameter int QW     = 2,
   parameter int LW     = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sbmq_pkg::qtab_ctl_type ctl,
   input  wire logic [QW-1:0]          rd_idx,
   input  wire logic [QW-1:0]          wr_idx,
   input  wire logic [LW-1:0]          wr_head,
   input  wire logic [LW-1:0]          wr_tail,
   output logic [LW-1:0]               rd_head,
   output logic [LW-1:0]               rd_tail
);

   localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

   logic [2*LW-1:0] tab_mem [QUEUES];
   logic [QUEUES-1:0] valid_ff;
   logic [2*LW-1:0]   rd_q_ff;
   logic              rd_valid_ff;

   // Entry valid bits: an unwritten queue reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         tab_mem[wr_idx] <= {wr_head, wr_tail};
      end
      if (ctl.rd_en) begin
         rd_q_ff <= tab_mem[rd_idx];
      end
   end

   assign rd_head = rd_valid_ff ? rd_q_ff[2*LW-1:LW] : NULL_LINK;
   assign rd_tail = rd_valid_ff ? rd_q_ff[LW-1:0]    : NULL_LINK;

endmodule

`default_nettype wire

### sv/shared_buffer_multi_queue_top.sv
// Top level: sequencer for the linked-list multi-queue over a shared slot store.
`default_nettype none

// QUEUES FIFO queues share SLOTS data slots; each queue is a linked list
// held in a next-link memory, with head and tail per queue in a queue-table
// memory and a free-list head in a register. Every request beat gives one
// response beat. One request is in work at a time: an enqueue, overflow,
// underflow or out-of-range queue number goes from acceptance through the
// lookup state to its result, a dequeue through lookup and pop, since the
// queue table read is registered and a dequeue then reads the head slot.
// A result waits in an output register and the next request is accepted
// meanwhile; a finished item holds its write-back until that register is
// free. No clearing pass is needed after reset: the slot chain is tracked
// with a watermark and the queue table with valid bits.
module shared_buffer_multi_queue_top #(
   parameter int SLOTS  = 16,
   parameter int QUEUES = 4
) (
   input wire logic    clock,
   input wire logic    reset,
   sbmq_req_if.sink    req_ch,
   sbmq_rsp_if.source  rsp_ch
);

   localparam int SW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 1);
   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_POP
   } state_type;

   state_type                          state_ff, state_in;
   logic                               op_ff, op_in;
   logic [QW-1:0]                      qidx_ff, qidx_in;
   logic                               inrange_ff, inrange_in;
   logic signed [sbmq_pkg::DATA_W-1:0] wdata_ff, wdata_in;
   logic [LW-1:0]                      free_head_ff, free_head_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [sbmq_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   sbmq_pkg::status_type               rsp_status_ff, rsp_status_in;

   sbmq_pkg::slot_ctl_type             slot_ctl;
   sbmq_pkg::qtab_ctl_type             qtab_ctl;
   logic [SW-1:0]                      slot_rd_addr;
   logic [LW-1:0]                      link_rd;
   logic signed [sbmq_pkg::DATA_W-1:0] data_rd;
   logic [QW-1:0]                      qtab_rd_idx;
   logic [LW-1:0]                      q_head, q_tail;
   logic [LW-1:0]                      qtab_wr_head, qtab_wr_tail;
   logic [SW-1:0]                      link_wr_addr;
   logic [LW-1:0]                      link_wr_data;

   logic accept, can_finish, free_null, head_null, req_inrange;

   sbmq_slots #(.SLOTS(SLOTS), .SW(SW), .LW(LW)) u_slots (
      .clock        (clock),
      .reset        (reset),
      .ctl          (slot_ctl),
      .rd_addr      (slot_rd_addr),
      .link_wr_addr (link_wr_addr),
      .link_wr_data (link_wr_data),
      .data_wr_addr (free_head_ff[SW-1:0]),
      .data_wr_data (wdata_ff),
      .link_rd_data (link_rd),
      .data_rd_data (data_rd)
   );

   sbmq_qtab #(.SLOTS(SLOTS), .QUEUES(QUEUES), .QW(QW), .LW(LW)) u_qtab (
      .clock   (clock),
      .reset   (reset),
      .ctl     (qtab_ctl),
      .rd_idx  (qtab_rd_idx),
      .wr_idx  (qidx_ff),
      .wr_head (qtab_wr_head),
      .wr_tail (qtab_wr_tail),
      .rd_head (q_head),
      .rd_tail (q_tail)
   );

   // Handshake terms
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign can_finish   = !rsp_valid_ff || rsp_ch.ready;
   assign free_null    = (free_head_ff == NULL_LINK);
   assign head_null    = (q_head == NULL_LINK);
   assign req_inrange  = (QUEUES >= 4) ||
                         (req_ch.queue_id < sbmq_pkg::qid_type'(QUEUES));
   assign qtab_rd_idx  = QW'(req_ch.queue_id);

   // Sequencer: look up the queue, read the head slot on a dequeue, then write
   // back links, queue entry and free head together; errors only respond.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      qidx_in       = qidx_ff;
      inrange_in    = inrange_ff;
      wdata_in      = wdata_ff;
      free_head_in  = free_head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      slot_ctl      = '0;
      qtab_ctl      = '0;
      slot_rd_addr  = free_head_ff[SW-1:0];
      link_wr_addr  = q_tail[SW-1:0];
      link_wr_data  = free_head_ff;
      qtab_wr_head  = q_head;
      qtab_wr_tail  = free_head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in          = req_ch.op;
               qidx_in        = QW'(req_ch.queue_id);
               inrange_in     = req_inrange;
               wdata_in       = req_ch.data_in;
               qtab_ctl.rd_en = req_inrange;
               slot_ctl.rd_en = (req_ch.op == sbmq_pkg::OP_ENQ) && !free_null;
               state_in       = S_LOOK;
            end
         end

         S_LOOK: begin
            if (!inrange_ff || (op_ff == sbmq_pkg::OP_ENQ && free_null) ||
                (op_ff == sbmq_pkg::OP_DEQ && head_null)) begin
               // Overflow, underflow or bad queue number: nothing changes
               if (can_finish) begin
                  rsp_valid_in = 1'b1;
                  if (op_ff == sbmq_pkg::OP_ENQ) begin
                     rsp_data_in   = '0;
                     rsp_status_in = sbmq_pkg::ST_OVERFLOW;
                  end else begin
                     rsp_data_in   = sbmq_pkg::MINUS_ONE;
                     rsp_status_in = sbmq_pkg::ST_UNDERFLOW;
                  end
                  state_in = S_IDLE;
               end
            end else if (op_ff == sbmq_pkg::OP_ENQ) begin
               // Enqueue: take the free head, append it after the tail
               if (can_finish) begin
                  slot_ctl.data_wr_en = 1'b1;
                  slot_ctl.alloc      = 1'b1;
                  slot_ctl.link_wr_en = !head_null;
                  link_wr_addr        = q_tail[SW-1:0];
                  link_wr_data        = free_head_ff;
                  qtab_ctl.wr_en      = 1'b1;
                  qtab_wr_head        = head_null ? free_head_ff : q_head;
                  qtab_wr_tail        = free_head_ff;
                  free_head_in        = link_rd;
                  rsp_valid_in        = 1'b1;
                  rsp_data_in         = '0;
                  rsp_status_in       = sbmq_pkg::ST_OK;
                  state_in            = S_IDLE;
               end
            end else begin
               // Dequeue: fetch link and data of the head slot
               slot_ctl.rd_en = 1'b1;
               slot_rd_addr   = q_head[SW-1:0];
               state_in       = S_POP;
            end
         end

         S_POP: begin
            // Unlink the head, push it on the free list, return its data
            if (can_finish) begin
               qtab_ctl.wr_en      = 1'b1;
               qtab_wr_head        = (q_head == q_tail) ? NULL_LINK : link_rd;
               qtab_wr_tail        = (q_head == q_tail) ? NULL_LINK : q_tail;
               slot_ctl.link_wr_en = 1'b1;
               link_wr_addr        = q_head[SW-1:0];
               link_wr_data        = free_head_ff;
               free_head_in        = q_head;
               rsp_valid_in        = 1'b1;
               rsp_data_in         = data_rd;
               rsp_status_in       = sbmq_pkg::ST_OK;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
         inrange_ff   <= 1'b0;
         op_ff        <= sbmq_pkg::OP_ENQ;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
         inrange_ff   <= inrange_in;
         op_ff        <= op_in;
      end
      qidx_ff       <= qidx_in;
      wdata_ff      <= wdata_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.data_out = rsp_data_ff;
   assign rsp_ch.status   = rsp_status_ff;

   // An accepted beat always moves on to the queue lookup
   a_accept_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOK))
      else $error("accepted beat did not enter lookup");

   // Pop stage only ever works on a dequeue of a non-empty queue
   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (!head_null && op_ff == sbmq_pkg::OP_DEQ))
      else $error("pop stage with empty queue or wrong operation");

   // A slot is only written when one was free
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      slot_ctl.data_wr_en |-> !free_null)
      else $error("slot written with free list empty");

   // Free head is a slot or null, never beyond
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= NULL_LINK)
      else $error("free head out of range");

   // Write-back never overruns a result still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(rsp_data_ff) && $stable(rsp_status_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire
